// ----- src/lkv_pkg.sv -----
// Shared constants, types and codes for the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

    // Sizing
    localparam int ENTRIES    = 8;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Transaction field widths
    localparam int FIELD_W    = 32;
    localparam int FUNC_W     = 2;
    localparam int CNT_W      = 32;
    localparam int IN_TDATA_W = 2 * FIELD_W;
    localparam int OUT_FLD_W  = 2 + 2 * FIELD_W + 4 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    // Stored widths: keys and values keep their low bits only
    localparam int KEY_W  = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int VAL_W  = (VALUE_BITS < FIELD_W) ? VALUE_BITS : FIELD_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;

    // Operation codes
    typedef logic [FUNC_W-1:0] func_t;
    localparam func_t FUNC_LOOKUP      = 2'd0;
    localparam func_t FUNC_CLEAR_STATS = 2'd1;
    localparam func_t FUNC_FLUSH       = 2'd2;

    // Entry storage views
    typedef logic [ENTRIES-1:0][KEY_W-1:0]  key_arr_t;
    typedef logic [ENTRIES-1:0][RANK_W-1:0] rank_arr_t;
    typedef logic [IDX_W-1:0]               idx_t;
    typedef logic [RANK_W-1:0]              rank_t;

    // Associative search result
    typedef struct packed {
        logic hit;
        idx_t hit_idx;
        logic free_found;
        idx_t free_idx;
        idx_t oldest_idx;
    } lookup_res_t;

    // Events for the statistics counters
    typedef struct packed {
        logic step;
        logic lookup;
        logic hit;
        logic evict;
        logic clear;
    } stats_ev_t;

endpackage

// ----- src/lkv_lookup.sv -----
// Parallel key compare, free-slot search and least-recent entry search.
`timescale 1ns / 1ps

module lkv_lookup (
    input  logic [lkv_pkg::KEY_W-1:0]   key,
    input  logic [lkv_pkg::ENTRIES-1:0] entry_valid,
    input  lkv_pkg::key_arr_t           entry_keys,
    input  lkv_pkg::rank_arr_t          entry_ranks,
    output lkv_pkg::lookup_res_t        res
);

    localparam lkv_pkg::rank_t OLDEST_RANK = lkv_pkg::RANK_W'(lkv_pkg::ENTRIES - 1);

    // First matching valid entry, first empty entry, entry holding the oldest rank.
    // The valid ranks are always a permutation of 0..count-1, so when the
    // cache is full the least recent entry is the one at the top rank.
    always_comb begin
        res = '0;
        for (int i = lkv_pkg::ENTRIES - 1; i >= 0; i--) begin
            if (entry_valid[i] && entry_keys[i] == key) begin
                res.hit     = 1'b1;
                res.hit_idx = lkv_pkg::IDX_W'(i);
            end
            if (!entry_valid[i]) begin
                res.free_found = 1'b1;
                res.free_idx   = lkv_pkg::IDX_W'(i);
            end
            if (entry_valid[i] && entry_ranks[i] == OLDEST_RANK) begin
                res.oldest_idx = lkv_pkg::IDX_W'(i);
            end
        end
    end

endmodule

// ----- src/lkv_stats.sv -----
// Saturating request, hit and eviction counters.
`timescale 1ns / 1ps

module lkv_stats (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lkv_pkg::stats_ev_t        ev,
    output logic [lkv_pkg::CNT_W-1:0] request_total,
    output logic [lkv_pkg::CNT_W-1:0] hit_total,
    output logic [lkv_pkg::CNT_W-1:0] miss_total,
    output logic [lkv_pkg::CNT_W-1:0] eviction_total
);

    logic [lkv_pkg::CNT_W-1:0] req_reg, req_next;
    logic [lkv_pkg::CNT_W-1:0] hit_reg, hit_next;
    logic [lkv_pkg::CNT_W-1:0] evc_reg, evc_next;

    // Next counts; a clear zeroes them, otherwise they stop at all ones
    always_comb begin
        req_next = req_reg;
        hit_next = hit_reg;
        evc_next = evc_reg;
        if (ev.clear) begin
            req_next = '0;
            hit_next = '0;
            evc_next = '0;
        end else begin
            if (ev.lookup && !(&req_reg)) req_next = req_reg + 1'b1;
            if (ev.hit && !(&hit_reg))    hit_next = hit_reg + 1'b1;
            if (ev.evict && !(&evc_reg))  evc_next = evc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= '0;
            hit_reg <= '0;
            evc_reg <= '0;
        end else if (ev.step) begin
            req_reg <= req_next;
            hit_reg <= hit_next;
            evc_reg <= evc_next;
        end
    end

    // Totals as they stand after this transaction
    assign request_total  = req_next;
    assign hit_total      = hit_next;
    assign eviction_total = evc_next;
    assign miss_total     = (hit_next > req_next) ? '0 : req_next - hit_next;

endmodule

// ----- src/lru_key_value_cache_unit.sv -----
// Fully associative key/value cache with LRU replacement, top level.
// An accepted transaction is held in the input register, and its result is registered in the result register.
// Throughput: one transaction per cycle while m_tready does not stall the result stage; the entry compare
// and rank update for an item finish between the input register and the result register.
// Reset clears the entry valid bits, recency ranks, counters and both pipeline stages;
// stored keys and values are left as they are.
`timescale 1ns / 1ps

module lru_key_value_cache_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lkv_pkg::IN_TDATA_W-1:0]  s_tdata,  // key[31:0], fill_value[63:32]
    input  logic [lkv_pkg::FUNC_W-1:0]      s_tuser,  // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lkv_pkg::OUT_TDATA_W-1:0] m_tdata   // hit[0], value[32:1], evicted[33],
                                                      // evicted_value[65:34],
                                                      // request_total[97:66],
                                                      // hit_total[129:98],
                                                      // miss_total[161:130],
                                                      // eviction_total[193:162], zero pad
);

    // Input stage
    logic                          in_valid_reg;
    lkv_pkg::func_t                func_reg;
    logic [lkv_pkg::KEY_W-1:0]     key_reg;
    logic [lkv_pkg::VAL_W-1:0]     fill_reg;

    // Result stage
    logic                             out_valid_reg;
    logic [lkv_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    // Entry storage
    lkv_pkg::key_arr_t                            key_mem_reg;
    logic [lkv_pkg::ENTRIES-1:0][lkv_pkg::VAL_W-1:0] val_mem_reg;
    logic [lkv_pkg::ENTRIES-1:0]                  valid_reg, valid_next;
    lkv_pkg::rank_arr_t                           rank_reg, rank_next;

    logic                  proc;
    logic                  is_lookup, is_clear, is_flush;
    logic                  hit, miss, evict;
    lkv_pkg::idx_t         slot, sel_idx;
    logic [lkv_pkg::VAL_W-1:0] sel_value;
    lkv_pkg::lookup_res_t  lk;
    lkv_pkg::stats_ev_t    ev;
    logic [lkv_pkg::CNT_W-1:0] request_total, hit_total, miss_total, eviction_total;

    // Handshake: the input stage moves on when the result stage is free or draining
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready)      in_valid_reg  <= s_tvalid;
            if (proc)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // Input payload capture
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg <= s_tuser;
            key_reg  <= s_tdata[lkv_pkg::KEY_W-1:0];
            fill_reg <= s_tdata[lkv_pkg::FIELD_W +: lkv_pkg::VAL_W];
        end
    end

    // Decode
    assign is_lookup = (func_reg == lkv_pkg::FUNC_LOOKUP);
    assign is_clear  = (func_reg == lkv_pkg::FUNC_CLEAR_STATS);
    assign is_flush  = (func_reg == lkv_pkg::FUNC_FLUSH);

    lkv_lookup u_lookup (
        .key         (key_reg),
        .entry_valid (valid_reg),
        .entry_keys  (key_mem_reg),
        .entry_ranks (rank_reg),
        .res         (lk)
    );

    assign hit   = is_lookup && lk.hit;
    assign miss  = is_lookup && !lk.hit;
    assign evict = miss && !lk.free_found;
    assign slot  = lk.free_found ? lk.free_idx : lk.oldest_idx;

    // One value read: the hit entry, or the victim on an eviction
    assign sel_idx   = lk.hit ? lk.hit_idx : lk.oldest_idx;
    assign sel_value = val_mem_reg[sel_idx];

    // Recency update and valid bits
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (proc) begin
            if (hit) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) != lk.hit_idx && valid_reg[i]
                        && rank_reg[i] < rank_reg[lk.hit_idx]) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[lk.hit_idx] = '0;
            end else if (miss) begin
                for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                    if (lkv_pkg::IDX_W'(i) != slot && valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[slot]  = '0;
                valid_next[slot] = 1'b1;
            end else if (is_flush) begin
                valid_next = '0;
                rank_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rank_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // Fill on a miss
    always_ff @(posedge aclk) begin
        if (proc && miss) begin
            key_mem_reg[slot] <= key_reg;
            val_mem_reg[slot] <= fill_reg;
        end
    end

    // Counters
    assign ev = '{step: proc, lookup: is_lookup, hit: hit, evict: evict, clear: is_clear};

    lkv_stats u_stats (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ev             (ev),
        .request_total  (request_total),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

    // Result packing
    always_comb begin
        out_data_next = '0;
        out_data_next[0] = hit;
        out_data_next[1 +: lkv_pkg::FIELD_W] =
            hit  ? lkv_pkg::FIELD_W'(sel_value) :
            miss ? lkv_pkg::FIELD_W'(fill_reg)  : '0;
        out_data_next[33] = evict;
        out_data_next[34 +: lkv_pkg::FIELD_W] =
            evict ? lkv_pkg::FIELD_W'(sel_value) : '0;
        out_data_next[66  +: lkv_pkg::CNT_W] = request_total;
        out_data_next[98  +: lkv_pkg::CNT_W] = hit_total;
        out_data_next[130 +: lkv_pkg::CNT_W] = miss_total;
        out_data_next[162 +: lkv_pkg::CNT_W] = eviction_total;
    end

    always_ff @(posedge aclk) begin
        if (proc) out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    // A flush leaves no valid entry behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && is_flush |=> valid_reg == '0)
        else $error("flush left valid entries");

    // A lookup always leaves at least one valid entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && is_lookup |=> valid_reg != '0)
        else $error("lookup left cache empty");

    // Eviction only happens with every entry in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc && evict |-> &valid_reg)
        else $error("eviction while a free entry exists");

    // A hit never reports an eviction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[33])
        else $error("hit and eviction in one result");

    // Hits never outnumber requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[129:98] <= m_tdata[97:66])
        else $error("hit count above request count");
`endif

endmodule
